>>> design/f32as_pkg.sv
// Shared types and constants for the single-precision add/subtract pipeline.
`default_nettype none
package f32as_pkg;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned MagW  = 31;  // 24-bit mantissa placed seven bits up
  localparam int unsigned SumW  = 32;
  localparam int unsigned NormW = 25;  // truncated sum keeps at most 25 bits

  typedef struct packed {
    logic [31:0] a_bits;
    logic [31:0] b_bits;
    logic        op;
  } f32as_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
  } f32as_out_t;
endpackage
`default_nettype wire

>>> design/f32as_if.sv
// Valid/ready channel interface carrying one payload per transaction.
`default_nettype none
interface f32as_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/float32_add_subtract.sv
// Single-precision add/subtract: truncating, no special values, four stages.
//
// Takes one transaction per clock when the output side keeps up. The stages
// are: align (exponent compare and right shift), add/subtract of the aligned
// magnitudes, leading-one search with truncation, and normalizing shift with
// exponent update. All stages advance together; a stalled output holds the
// whole pipeline. A truncated sum of zero gives +0; the exponent wraps
// mod 256.
`default_nettype none
module float32_add_subtract
  import f32as_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  f32as_if.sink     in_i,
  f32as_if.source   out_o
);
  logic adv;
  logic [3:0] vld_q;
  assign adv       = !vld_q[3] || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: align.
  logic        s1_sa_q, s1_sb_q;
  logic [ExpW-1:0] s1_ex_q;
  logic [MagW-1:0] s1_ma_q, s1_mb_q;
  logic        sa, sb, a_small;
  logic [ExpW-1:0] ea, eb, dd;
  logic [MagW-1:0] ma, mb, msh;
  always_comb begin
    sa = in_i.payload.a_bits[31];
    sb = in_i.payload.b_bits[31] ^ in_i.payload.op;
    ea = in_i.payload.a_bits[30:23];
    eb = in_i.payload.b_bits[30:23];
    ma = {1'b1, in_i.payload.a_bits[FracW-1:0], 7'd0};
    mb = {1'b1, in_i.payload.b_bits[FracW-1:0], 7'd0};
    a_small = ea < eb;
    dd = a_small ? eb - ea : ea - eb;
    msh = (dd >= 8'd32) ? '0 : ((a_small ? ma : mb) >> dd[4:0]);
  end

  // Stage 2: add or subtract.
  logic        s2_sr_q;
  logic [ExpW-1:0] s2_ex_q;
  logic [SumW-1:0] s2_r_q;
  logic        a_ge;
  always_comb a_ge = s1_ma_q >= s1_mb_q;

  // Stage 3: truncate and find leading one.
  logic        s3_sr_q, s3_z_q;
  logic [ExpW-1:0] s3_ex_q;
  logic [NormW-1:0] s3_r_q;
  logic [4:0]  s3_lz_q;
  logic [NormW-1:0] tr;
  logic [4:0]  lead;
  always_comb begin
    tr = s2_r_q[SumW-1:7];
    lead = '0;
    for (int i = 0; i < NormW; i++) begin
      if (tr[i]) lead = 5'(i);
    end
  end

  // Stage 4: normalize.
  logic [31:0] res_q;
  logic [NormW-1:0] nr;
  logic [ExpW-1:0] nex;
  always_comb begin
    if (s3_lz_q >= 5'd23) begin
      nr  = s3_r_q >> (s3_lz_q - 5'd23);
      nex = s3_ex_q + ExpW'(s3_lz_q - 5'd23);
    end else begin
      nr  = s3_r_q << (5'd23 - s3_lz_q);
      nex = s3_ex_q - ExpW'(5'd23 - s3_lz_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sa_q <= sa;
      s1_sb_q <= sb;
      s1_ex_q <= a_small ? eb : ea;
      s1_ma_q <= a_small ? msh : ma;
      s1_mb_q <= a_small ? mb : msh;

      s2_sr_q <= a_ge ? s1_sa_q : s1_sb_q;
      s2_ex_q <= s1_ex_q;
      if (s1_sa_q ^ s1_sb_q) begin
        s2_r_q <= a_ge ? SumW'(s1_ma_q - s1_mb_q) : SumW'(s1_mb_q - s1_ma_q);
      end else begin
        s2_r_q <= SumW'(s1_ma_q) + SumW'(s1_mb_q);
      end

      s3_sr_q <= s2_sr_q;
      s3_ex_q <= s2_ex_q;
      s3_r_q  <= tr;
      s3_lz_q <= lead;
      s3_z_q  <= tr == '0;

      res_q <= s3_z_q ? 32'd0 : {s3_sr_q, nex, nr[FracW-1:0]};
    end
  end

  assign out_o.valid = vld_q[3];
  assign out_o.payload.result_bits = res_q;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(res_q))
    else $error("result dropped while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("pipeline stalled with empty output");
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !s3_z_q |-> s3_r_q[s3_lz_q] == 1'b1)
    else $error("leading one mislocated");
`endif
endmodule
`default_nettype wire
